// ----- design/sra_pkg.sv -----
package sra_pkg;

    // Default row length and the width of slot numbers on the ports.
    localparam int DEFAULT_NUM_SLOTS = 64;
    localparam int SLOT_W            = 16;

    // Command codes carried in the request.
    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_MARK_USED = 3'd1,
        CMD_MARK_FREE = 3'd2,
        CMD_CLAIM     = 3'd3,
        CMD_CLEAR     = 3'd4
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BOUNDS  = 2'd2,
        ST_OVERLAP = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_RESULT
    } state_t;

    // One request item.
    typedef struct packed {
        logic [2:0]        cmd;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] span;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] run_start;
    } rsp_t;

    // Control from the sequencer to the row of slot cells.
    typedef struct packed {
        logic shift;
        logic clear;
        logic feed;
    } ring_ctl_t;

endpackage

// ----- design/sra_cell.sv -----
module sra_cell
    import sra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ring_ctl_t ctl,
    input  logic      d_in,
    output logic      used
);

    logic used_reg;
    logic used_next;

    // The cell takes its neighbor's bit on a shift and drops to free on a clear.
    always_comb
    begin
        used_next = used_reg;
        if (ctl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            used_next = d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign used = used_reg;

endmodule

// ----- design/sra_ctrl.sv -----
module sra_ctrl
    import sra_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  req_t      req,
    input  logic      head,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp,
    output ring_ctl_t ctl
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [SLOT_W:0] NUM_SLOTS_X = (SLOT_W + 1)'(NUM_SLOTS);

    state_t            state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [SLOT_W-1:0] first_reg, first_next;
    logic [SLOT_W-1:0] span_reg, span_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     start_reg, start_next;
    logic              overlap_reg, overlap_next;
    logic              claim_mark_reg, claim_mark_next;
    rsp_t              rsp_reg, rsp_next;

    logic              accept;
    logic              immediate;
    logic              alloc_bad;
    logic              claim_bad;
    logic [SLOT_W:0]   req_end;
    logic [SLOT_W:0]   run_end;
    logic [SLOT_W-1:0] s_wide;
    logic              in_run;
    logic              last_step;
    logic              overlap_any;
    logic [CW-1:0]     cnt_step;

    // Handshake and the checks that settle an item without a pass.
    assign busy      = (state_reg == S_PASS);
    assign done      = (state_reg == S_RESULT);
    assign rsp       = rsp_reg;
    assign accept    = start && !busy;
    assign req_end   = {1'b0, req.first_slot} + {1'b0, req.span};
    assign alloc_bad = (req.span == '0) || ({1'b0, req.span} > NUM_SLOTS_X);
    assign claim_bad = (req.span == '0) || (req_end > NUM_SLOTS_X);

    always_comb
    begin
        unique case (req.cmd)
            CMD_ALLOC:     immediate = alloc_bad;
            CMD_MARK_USED: immediate = 1'b0;
            CMD_MARK_FREE: immediate = 1'b0;
            CMD_CLAIM:     immediate = claim_bad;
            default:       immediate = 1'b1;
        endcase
    end

    // Position of the slot now at the head of the row.
    assign run_end     = {1'b0, first_reg} + {1'b0, span_reg};
    assign s_wide      = SLOT_W'(s_reg);
    assign in_run      = (s_wide >= first_reg) && ({1'b0, s_wide} < run_end);
    assign last_step   = (state_reg == S_PASS) && (s_reg == '0);
    assign overlap_any = overlap_reg || (in_run && head);
    assign cnt_step    = head ? '0 : cnt_reg + CW'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE, S_RESULT:
            begin
                if (accept)
                begin
                    state_next = immediate ? S_RESULT : S_PASS;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PASS:
            begin
                if (last_step)
                begin
                    if ((cmd_reg == CMD_CLAIM) && !claim_mark_reg && !overlap_any)
                    begin
                        state_next = S_PASS;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, row control and result.
    always_comb
    begin
        cmd_next        = cmd_reg;
        first_next      = first_reg;
        span_next       = span_reg;
        s_next          = s_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        overlap_next    = overlap_reg;
        claim_mark_next = claim_mark_reg;
        rsp_next        = rsp_reg;
        ctl             = '0;

        if (accept)
        begin
            cmd_next           = req.cmd;
            first_next         = req.first_slot;
            span_next          = req.span;
            s_next             = LAST_SLOT;
            cnt_next           = '0;
            found_next         = 1'b0;
            start_next         = '0;
            overlap_next       = 1'b0;
            claim_mark_next    = 1'b0;
            rsp_next.status    = ST_OK;
            rsp_next.run_start = '0;
            if ((req.cmd == CMD_ALLOC) && alloc_bad)
            begin
                rsp_next.status = ST_NOSPACE;
            end
            else if ((req.cmd == CMD_CLAIM) && claim_bad)
            begin
                rsp_next.status = ST_BOUNDS;
            end
            ctl.clear = (req.cmd == CMD_CLEAR);
        end
        else if (state_reg == S_PASS)
        begin
            // The row turns once per pass; the head bit re-enters at cell zero.
            ctl.shift = 1'b1;
            ctl.feed  = head;
            s_next    = s_reg - SW'(1);
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    cnt_next = cnt_step;
                    if (span_reg == SLOT_W'(1))
                    begin
                        // Top-down scan: the last free slot seen is the lowest.
                        if (!head)
                        begin
                            found_next = 1'b1;
                            start_next = s_reg;
                        end
                    end
                    else if (!found_reg && (SLOT_W'(cnt_step) >= span_reg))
                    begin
                        found_next = 1'b1;
                        start_next = s_reg;
                    end
                end
                CMD_MARK_USED: ctl.feed = in_run ? 1'b1 : head;
                CMD_MARK_FREE: ctl.feed = in_run ? 1'b0 : head;
                CMD_CLAIM:
                begin
                    if (claim_mark_reg)
                    begin
                        ctl.feed = in_run ? 1'b1 : head;
                    end
                    else
                    begin
                        overlap_next = overlap_any;
                    end
                end
                default: ctl.feed = head;
            endcase

            if (last_step)
            begin
                rsp_next.status    = ST_OK;
                rsp_next.run_start = '0;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (found_next)
                    begin
                        rsp_next.run_start = SLOT_W'(start_next);
                    end
                    else
                    begin
                        rsp_next.status = ST_NOSPACE;
                    end
                end
                else if ((cmd_reg == CMD_CLAIM) && !claim_mark_reg)
                begin
                    if (overlap_any)
                    begin
                        rsp_next.status = ST_OVERLAP;
                    end
                    else
                    begin
                        // Check pass was clean: turn the row again and mark.
                        claim_mark_next = 1'b1;
                        s_next          = LAST_SLOT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        first_reg      <= first_next;
        span_reg       <= span_next;
        s_reg          <= s_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        start_reg      <= start_next;
        overlap_reg    <= overlap_next;
        claim_mark_reg <= claim_mark_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ----- design/slot_run_allocator.sv -----
// Channel   Ports                   Direction  Transfer
// request   start, busy, req        in         start high while busy low
// result    done, rsp               out        done high for one cycle
//
// Allocate and mark commands turn the row of slot cells once, one slot per
// cycle, and then show the result. Claim turns the row twice (check, then
// mark) when the run is free, and once when the check finds an overlap.
// Clear, unused codes and items rejected on span or bounds answer after one cycle.
// Reset frees every slot at once. The receiver cannot stall; a new item is
// taken in the cycle its predecessor's result is shown.
module slot_run_allocator
    import sra_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    ring_ctl_t            ctl;
    logic [NUM_SLOTS-1:0] used;

    // Sequencer: handshake, scan counters and result register.
    sra_ctrl #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .head (used[NUM_SLOTS-1]),
        .busy (busy),
        .done (done),
        .rsp  (rsp),
        .ctl  (ctl)
    );

    // Row of slot cells closed into a ring through the sequencer.
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            sra_cell u_cell (
                .clk (clk),
                .rst_n(rst_n),
                .ctl (ctl),
                .d_in(ctl.feed),
                .used(used[i])
            );
        end
        else
        begin : g_rest
            sra_cell u_cell (
                .clk (clk),
                .rst_n(rst_n),
                .ctl (ctl),
                .d_in(used[i-1]),
                .used(used[i])
            );
        end
    end

endmodule

// ----- design/sra_checker.sv -----
module sra_checker
    import sra_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    logic accept;

    assign accept = start && !busy;

    // A run start is reported only on success.
    a_start_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.run_start != '0)) |-> (rsp.status == ST_OK))
        else $error("run_start nonzero on a failed result");

    // Clear answers ok in the next cycle.
    a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_CLEAR)) |=> (done && (rsp.status == ST_OK)))
        else $error("clear did not answer ok at once");

    // Allocate with a zero span answers no-space in the next cycle.
    a_alloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_ALLOC) && (req.span == '0))
        |=> (done && (rsp.status == ST_NOSPACE) && (rsp.run_start == '0)))
        else $error("zero-span allocate not rejected");

    // Every accepted item is either at work or answered next cycle.
    a_item_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted item dropped");

    // The end of a pass always shows a result.
    a_pass_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("pass ended without a result");

endmodule

bind slot_run_allocator sra_checker u_sra_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
);

// ----- tb/slot_run_allocator_tb.sv -----
module slot_run_allocator_tb;
    import sra_pkg::*;

    localparam int NUM_SLOTS      = DEFAULT_NUM_SLOTS;
    localparam int RESULT_LATENCY = 2 * NUM_SLOTS + 1;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int DRAIN_EVERY    = 300;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int FIELD_MAX      = (1 << SLOT_W) - 1;

    // First of the command codes that the block leaves undefined.
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;

    // One queued command with its pacing controls.
    typedef struct {
        req_t item;
        bit   drain_first;
        bit   use_found;
    } pend_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    pend_t cmd_backlog[$];
    rsp_t  owed_results[$];

    // Shadow of the slot bitmap and bookkeeping from the predictor.
    logic [NUM_SLOTS-1:0] used_model = '0;
    logic [SLOT_W-1:0]    last_found = '0;
    int alloc_found   = 0;
    int alloc_missed  = 0;

    int items_taken   = 0;
    int results_seen  = 0;
    int failures      = 0;
    int cycle_count   = 0;
    int burst_left    = 1;
    int gap_left      = 0;

    slot_run_allocator #(.NUM_SLOTS(NUM_SLOTS)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    // Apply one command to the shadow bitmap and return the result it should give.
    function automatic rsp_t apply_command(req_t item);
        rsp_t        res;
        int unsigned first;
        int unsigned span;
        int unsigned stop;
        int unsigned run;
        int unsigned s;
        bit          hit;
        res   = '0;
        first = 32'(item.first_slot);
        span  = 32'(item.span);
        hit   = 1'b0;
        case (item.cmd)
            CMD_ALLOC:
            begin
                if (span == 1)
                begin
                    // A single slot goes to the lowest free one.
                    for (s = 0; s < NUM_SLOTS && !hit; s++)
                    begin
                        if (!used_model[s])
                        begin
                            hit           = 1'b1;
                            res.run_start = SLOT_W'(s);
                        end
                    end
                end
                else if (span >= 2 && span <= NUM_SLOTS)
                begin
                    // Scan downward with a running free count; first fit has the highest start.
                    run = 0;
                    for (s = NUM_SLOTS; s > 0 && !hit; s--)
                    begin
                        run = used_model[s-1] ? 0 : run + 1;
                        if (run >= span)
                        begin
                            hit           = 1'b1;
                            res.run_start = SLOT_W'(s - 1);
                        end
                    end
                end
                if (hit)
                begin
                    res.status = ST_OK;
                    last_found = res.run_start;
                    alloc_found++;
                end
                else
                begin
                    res.status    = ST_NOSPACE;
                    res.run_start = '0;
                    alloc_missed++;
                end
            end
            CMD_MARK_USED, CMD_MARK_FREE:
            begin
                // Slots past the end of the row are skipped.
                stop = first + span;
                if (stop > NUM_SLOTS)
                    stop = NUM_SLOTS;
                for (s = first; s < stop; s++)
                    used_model[s] = (item.cmd == CMD_MARK_USED);
            end
            CMD_CLAIM:
            begin
                if (span == 0 || first + span > NUM_SLOTS)
                begin
                    res.status = ST_BOUNDS;
                end
                else
                begin
                    for (s = first; s < first + span; s++)
                        if (used_model[s])
                            hit = 1'b1;
                    if (hit)
                        res.status = ST_OVERLAP;
                    else
                        for (s = first; s < first + span; s++)
                            used_model[s] = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                used_model = '0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Append one command to the backlog.
    task automatic push_cmd(input logic [2:0] code, input int unsigned first,
                            input int unsigned span, input bit hold, input bit follow);
        pend_t p;
        p.item.cmd        = code;
        p.item.first_slot = SLOT_W'(first);
        p.item.span       = SLOT_W'(span);
        p.drain_first     = hold;
        p.use_found       = follow;
        cmd_backlog.push_back(p);
    endtask

    // Driver: predicts each accepted item and presents the next one in bursts.
    always @(posedge clk)
    begin
        rsp_t  predicted;
        pend_t nxt;
        bit    hold_on;
        int    outstanding;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            hold_on     = start;
            outstanding = items_taken - results_seen;
            if (start && !busy)
            begin
                predicted = apply_command(req);
                owed_results.push_back(predicted);
                items_taken <= items_taken + 1;
                outstanding++;
                hold_on = 1'b0;
            end
            if (!hold_on)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].drain_first || outstanding == 0))
                begin
                    nxt = cmd_backlog.pop_front();
                    // A follow-up claim takes the run that the last allocation found.
                    if (nxt.use_found)
                        nxt.item.first_slot = last_found;
                    req     <= nxt.item;
                    hold_on  = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(9))
                            0, 1, 2:    gap_left = 0;
                            3, 4, 5, 6: gap_left = $urandom_range(1, 8);
                            default:    gap_left = $urandom_range(9, 100);
                        endcase
                    end
                end
            end
            start <= hold_on;
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (owed_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d run_start %0d",
                       rsp.status, rsp.run_start);
                failures++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    failures++;
                end
                if (rsp.run_start !== want.run_start)
                begin
                    $error("run_start: expected %0d, actual %0d",
                           want.run_start, rsp.run_start);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int count;
        int roll;
        int span;
        int first;
        int next_hold;
        int k;
        bit hold;

        // Directed commands on an empty row first.
        push_cmd(CMD_ALLOC, 0, 1, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, NUM_SLOTS, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, 0, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, NUM_SLOTS + 1, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, FIELD_MAX, FIELD_MAX, 1'b0, 1'b0);
        // Claims outside the row or with no slots.
        push_cmd(CMD_CLAIM, 0, 0, 1'b0, 1'b0);
        push_cmd(CMD_CLAIM, NUM_SLOTS - 4, 5, 1'b0, 1'b0);
        push_cmd(CMD_CLAIM, FIELD_MAX, FIELD_MAX, 1'b0, 1'b0);
        // Fill the row, then try to allocate and to claim over used slots.
        push_cmd(CMD_CLAIM, 0, NUM_SLOTS, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, 1, 1'b0, 1'b0);
        push_cmd(CMD_CLAIM, 10, 1, 1'b0, 1'b0);
        // Free the upper half with a run running past the end.
        push_cmd(CMD_MARK_FREE, NUM_SLOTS / 2, FIELD_MAX, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, 2, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, NUM_SLOTS / 2, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, NUM_SLOTS / 2 + 1, 1'b0, 1'b0);
        // Marks wholly past the end or with no slots change nothing; then one slot is freed again.
        push_cmd(CMD_MARK_USED, FIELD_MAX, FIELD_MAX, 1'b0, 1'b0);
        push_cmd(CMD_MARK_USED, 40, 0, 1'b0, 1'b0);
        push_cmd(CMD_MARK_FREE, 0, 1, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, 1, 1'b0, 1'b0);
        push_cmd(CMD_CLAIM, NUM_SLOTS - 1, 1, 1'b0, 1'b0);
        // Undefined codes leave the row alone; a clear then empties it.
        for (k = 0; k < 3; k++)
            push_cmd(3'(CMD_FIRST_UNUSED + k), $urandom_range(FIELD_MAX),
                     $urandom_range(FIELD_MAX), 1'b0, 1'b0);
        push_cmd(CMD_CLEAR, FIELD_MAX, FIELD_MAX, 1'b0, 1'b0);
        push_cmd(CMD_ALLOC, 0, NUM_SLOTS, 1'b0, 1'b0);

        // Random traffic: allocations (some followed by a claim), claims, marks, frees, clears and other codes.
        count     = 0;
        next_hold = 0;
        while (count < RANDOM_ITEMS)
        begin
            hold = (count >= next_hold);
            if (hold)
                next_hold += DRAIN_EVERY;
            roll = $urandom_range(99);
            if (roll < 30)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: span = 1;
                    4, 5, 6, 7: span = $urandom_range(2, 12);
                    8:          span = $urandom_range(13, NUM_SLOTS);
                    default:    span = $urandom_range(1) ? 0
                                       : $urandom_range(NUM_SLOTS + 1, FIELD_MAX);
                endcase
                push_cmd(CMD_ALLOC, $urandom_range(FIELD_MAX), span, hold, 1'b0);
                count++;
                if ($urandom_range(1))
                begin
                    push_cmd(CMD_CLAIM, 0, span, 1'b0, 1'b1);
                    count++;
                end
            end
            else
            begin
                first = $urandom_range(NUM_SLOTS - 1);
                if (roll < 45)
                begin
                    span = $urandom_range(1, (NUM_SLOTS - first < 8) ? NUM_SLOTS - first : 8);
                    push_cmd(CMD_CLAIM, first, span, hold, 1'b0);
                end
                else if (roll < 58)
                    push_cmd(CMD_MARK_USED, first, $urandom_range(10), hold, 1'b0);
                else if (roll < 73)
                    push_cmd(CMD_MARK_FREE, first, $urandom_range(24), hold, 1'b0);
                else if (roll < 76)
                    push_cmd(CMD_CLEAR, $urandom_range(FIELD_MAX),
                             $urandom_range(FIELD_MAX), hold, 1'b0);
                else if (roll < 78)
                    push_cmd(3'(CMD_FIRST_UNUSED + $urandom_range(2)),
                             $urandom_range(FIELD_MAX),
                             $urandom_range(FIELD_MAX), hold, 1'b0);
                else
                    push_cmd(3'($urandom_range(7)), $urandom_range(FIELD_MAX),
                             $urandom_range(FIELD_MAX), hold, 1'b0);
                count++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog and every owed result, then watch for stray strobes.
        while (cmd_backlog.size() != 0 || start || owed_results.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 8) @(negedge clk);

        $display("Drove %0d commands; allocations found %0d runs and reported %0d misses.",
                 items_taken, alloc_found, alloc_missed);
        $display("Checked %0d results with %0d mismatches.", results_seen, failures);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
